// ----- rtl/bdq_pkg.sv -----
// ============================================================================
// bdq_pkg
// Shared types and constants for the bounded deque with value delete.
// ============================================================================
package bdq_pkg;

    localparam int DEPTH  = 16;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int CNT_W  = ADDR_W + 1;
    localparam int DATA_W = 32;

    typedef enum logic [2:0] {
        ACT_PUSH_FRONT = 3'd0,
        ACT_PUSH_BACK  = 3'd1,
        ACT_POP_FRONT  = 3'd2,
        ACT_POP_BACK   = 3'd3,
        ACT_PEEK_FRONT = 3'd4,
        ACT_PEEK_BACK  = 3'd5,
        ACT_DELETE     = 3'd6,
        ACT_NONE       = 3'd7
    } action_t;

    typedef enum logic [1:0] {
        STAT_OK    = 2'd0,
        STAT_FULL  = 2'd1,
        STAT_EMPTY = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_DEL_CHK,
        S_FIN
    } state_t;

    localparam logic [2:0] REG_CAPACITY = 3'd0;

endpackage

// ----- rtl/bdq_ram.sv -----
// ============================================================================
// bdq_ram
// Generic single-write, single-read RAM with registered read data.
// ============================================================================
module bdq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- rtl/bounded_deque_with_value_delete.sv -----
// ============================================================================
// bounded_deque_with_value_delete
// Bounded double-ended queue of signed 32-bit values in a ring buffer, with
// push/pop/peek at both ends and an in-place delete of all matching values.
// ============================================================================
//
//  channel   dir  handshake          payload
//  -------   ---  ---------          -------
//  s_*       in   s_valid/s_ready    s_action[2:0], s_value[31:0]
//  m_*       out  m_valid/m_ready    m_data, m_count, m_empty_res, m_full_res,
//                                    m_status
//  apb       in   psel/penable       paddr[2:0], pwdata, prdata (capacity)
//
//  Push, pop, peek: accept in IDLE, then FIN loads the result into the output reg.
//  Delete: DEL_CHK walks N entries, N = entries held; one RAM read and compare per entry,
//  through the single RAM read port shared by the walk, then FIN loads the result.
//  One request in flight; s_ready is high only in IDLE. A stalled result sits
//  in the output register and a new request can be accepted meanwhile.
//  Reset (aresetn low, synchronous): empty deque, capacity 16; RAM not cleared.
//
module bounded_deque_with_value_delete
    import bdq_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    // request channel
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [2:0]           s_action,
    input  logic signed [31:0]   s_value,
    // result channel
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic signed [31:0]   m_data,
    output logic [4:0]           m_count,
    output logic                 m_empty_res,
    output logic                 m_full_res,
    output logic [1:0]           m_status,
    // config port
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [2:0]           paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready
);

    // ------------------------------------------------------------------
    // State
    // ------------------------------------------------------------------
    state_t                 state_reg, state_next;
    logic [ADDR_W-1:0]      head_reg, head_next;
    logic [CNT_W-1:0]       count_reg, count_next;
    logic [CNT_W-1:0]       cap_reg;
    logic [DATA_W-1:0]      value_reg, value_next;
    logic [CNT_W-1:0]       idx_reg, idx_next;      // delete: read position
    logic [CNT_W-1:0]       kept_reg, kept_next;    // delete: write position
    status_t                stat_reg, stat_next;
    logic                   use_rd_reg, use_rd_next; // result data comes from RAM

    // output register
    logic                   m_valid_reg, m_valid_next;
    logic [DATA_W-1:0]      m_data_reg, m_data_next;
    logic [CNT_W-1:0]       m_count_reg, m_count_next;
    logic                   m_empty_reg, m_empty_next;
    logic                   m_full_reg, m_full_next;
    status_t                m_status_reg, m_status_next;

    // RAM port signals
    logic                   ram_we;
    logic [ADDR_W-1:0]      ram_waddr;
    logic [DATA_W-1:0]      ram_wdata;
    logic                   ram_re;
    logic [ADDR_W-1:0]      ram_raddr;
    logic [DATA_W-1:0]      ram_rdata;

    logic [CNT_W-1:0]       limit;
    logic                   accept;
    logic                   out_free;
    logic                   del_keep;
    logic                   del_last;
    logic                   cfg_wr;

    bdq_ram #(
        .WIDTH (DATA_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // ------------------------------------------------------------------
    // Config port: capacity at byte address 0, always ready
    // ------------------------------------------------------------------
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_CAPACITY[0]);
    assign prdata = (paddr[2] == REG_CAPACITY[0]) ? {{(32-CNT_W){1'b0}}, cap_reg} : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cap_reg <= CNT_W'(DEPTH);
        end else if (cfg_wr) begin
            cap_reg <= pwdata[CNT_W-1:0];
        end
    end

    // limit in force is min(capacity, DEPTH)
    assign limit = (cap_reg > CNT_W'(DEPTH)) ? CNT_W'(DEPTH) : cap_reg;

    // ------------------------------------------------------------------
    // Handshake helpers
    // ------------------------------------------------------------------
    assign s_ready  = (state_reg == S_IDLE);
    assign accept   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;

    // delete walk: entry just read is kept when it differs from the value
    assign del_keep = (ram_rdata != value_reg);
    assign del_last = ((idx_reg + 1'b1) == count_reg);

    // ------------------------------------------------------------------
    // Next state
    // ------------------------------------------------------------------
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    if (s_action == ACT_DELETE && count_reg != '0) begin
                        state_next = S_DEL_CHK;
                    end else begin
                        state_next = S_FIN;
                    end
                end
            end
            S_DEL_CHK: begin
                if (del_last) begin
                    state_next = S_FIN;
                end
            end
            S_FIN: begin
                if (out_free) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // ------------------------------------------------------------------
    // Datapath and RAM control
    // ------------------------------------------------------------------
    always_comb begin
        head_next   = head_reg;
        count_next  = count_reg;
        value_next  = value_reg;
        idx_next    = idx_reg;
        kept_next   = kept_reg;
        stat_next   = stat_reg;
        use_rd_next = use_rd_reg;
        ram_we      = 1'b0;
        ram_waddr   = head_reg;
        ram_wdata   = s_value;
        ram_re      = 1'b0;
        ram_raddr   = head_reg;

        case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    value_next  = s_value;
                    stat_next   = STAT_OK;
                    use_rd_next = 1'b0;
                    idx_next    = '0;
                    kept_next   = '0;
                    case (s_action)
                        ACT_PUSH_FRONT, ACT_PUSH_BACK: begin
                            if (count_reg >= limit) begin
                                stat_next = STAT_FULL;
                            end else begin
                                ram_we     = 1'b1;
                                count_next = count_reg + 1'b1;
                                if (s_action == ACT_PUSH_FRONT) begin
                                    head_next = head_reg - 1'b1;
                                    ram_waddr = head_reg - 1'b1;
                                end else begin
                                    ram_waddr = head_reg + count_reg[ADDR_W-1:0];
                                end
                            end
                        end
                        ACT_POP_FRONT, ACT_POP_BACK, ACT_PEEK_FRONT, ACT_PEEK_BACK: begin
                            if (count_reg == '0) begin
                                stat_next = STAT_EMPTY;
                            end else begin
                                ram_re      = 1'b1;
                                use_rd_next = 1'b1;
                                if (s_action inside {ACT_POP_FRONT, ACT_PEEK_FRONT}) begin
                                    ram_raddr = head_reg;
                                end else begin
                                    ram_raddr = head_reg + count_reg[ADDR_W-1:0] - 1'b1;
                                end
                                if (s_action == ACT_POP_FRONT) begin
                                    head_next  = head_reg + 1'b1;
                                    count_next = count_reg - 1'b1;
                                end else if (s_action == ACT_POP_BACK) begin
                                    count_next = count_reg - 1'b1;
                                end
                            end
                        end
                        ACT_DELETE: begin
                            // first read of the walk goes out with the accept
                            ram_re    = (count_reg != '0);
                            ram_raddr = head_reg;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_DEL_CHK: begin
                // compact in place: write kept entries at head + kept
                ram_we    = del_keep;
                ram_waddr = head_reg + kept_reg[ADDR_W-1:0];
                ram_wdata = ram_rdata;
                if (del_keep) begin
                    kept_next = kept_reg + 1'b1;
                end
                idx_next = idx_reg + 1'b1;
                if (del_last) begin
                    count_next = kept_reg + CNT_W'(del_keep);
                end else begin
                    ram_re    = 1'b1;
                    ram_raddr = head_reg + idx_reg[ADDR_W-1:0] + 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Output register
    // ------------------------------------------------------------------
    always_comb begin
        m_valid_next  = m_valid_reg && !m_ready;
        m_data_next   = m_data_reg;
        m_count_next  = m_count_reg;
        m_empty_next  = m_empty_reg;
        m_full_next   = m_full_reg;
        m_status_next = m_status_reg;
        if (state_reg == S_FIN && out_free) begin
            m_valid_next  = 1'b1;
            m_data_next   = use_rd_reg ? ram_rdata : '0;
            m_count_next  = count_reg;
            m_empty_next  = (count_reg == '0);
            m_full_next   = (count_reg >= limit);
            m_status_next = stat_reg;
        end
    end

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            head_reg    <= '0;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            head_reg    <= head_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        value_reg    <= value_next;
        idx_reg      <= idx_next;
        kept_reg     <= kept_next;
        stat_reg     <= stat_next;
        use_rd_reg   <= use_rd_next;
        m_data_reg   <= m_data_next;
        m_count_reg  <= m_count_next;
        m_empty_reg  <= m_empty_next;
        m_full_reg   <= m_full_next;
        m_status_reg <= m_status_next;
    end

    assign m_valid     = m_valid_reg;
    assign m_data      = m_data_reg;
    assign m_count     = m_count_reg;
    assign m_empty_res = m_empty_reg;
    assign m_full_res  = m_full_reg;
    assign m_status    = m_status_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(DEPTH))
        else $error("entry count above depth");

    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> !s_ready)
        else $error("second request taken while one is in flight");

    a_fin_loads: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_FIN && out_free) |=> m_valid)
        else $error("finished request did not reach output register");

    a_empty_flag: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_empty_res == (m_count == '0)))
        else $error("empty flag disagrees with count");

endmodule
